@@ hdl/serf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serf_pkg: shared types and constants
// Transaction structs, configuration register file type, register indexes
// and reset values for the sonar echo ranging filter.
// ----------------------------------------------------------------------------
package serf_pkg;

  localparam int CounterBitsDef = 16;
  localparam int CfgIdxW        = 3;
  localparam int CfgDataW       = 16;
  localparam int WidthW         = 16;
  localparam int ErrW           = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegTrigCmp   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMinWidth  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMaxWidth  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegErrLimit  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFallback  = 3'd4;

  // configuration reset values
  localparam logic [WidthW-1:0] TrigCmpRst  = 16'd65510;
  localparam logic [WidthW-1:0] MinWidthRst = 16'd354;
  localparam logic [WidthW-1:0] MaxWidthRst = 16'd59000;
  localparam logic [ErrW-1:0]   ErrLimitRst = 8'd50;
  localparam logic [WidthW-1:0] FallbackRst = 16'd65490;

  localparam logic [ErrW-1:0]   ErrMax      = 8'd255;

  typedef struct packed {
    logic echo_level;
    logic read_request;
  } in_t;

  typedef struct packed {
    logic              trigger_level;
    logic              read_done;
    logic [WidthW-1:0] distance_ticks;
    logic [ErrW-1:0]   invalid_count;
  } out_t;

  typedef struct packed {
    logic [WidthW-1:0] trigger_compare;
    logic [WidthW-1:0] min_valid_width;
    logic [WidthW-1:0] max_valid_width;
    logic [ErrW-1:0]   error_limit;
    logic [WidthW-1:0] fallback_width;
  } cfg_t;

endpackage

@@ hdl/serf_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serf_core: tick timer, echo timing and read filter
// Holds the ranging state and works one tick per step; the result for the
// stepped tick is presented combinationally.
// ----------------------------------------------------------------------------
module serf_core #(
  parameter int COUNTER_BITS = serf_pkg::CounterBitsDef
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  serf_pkg::in_t  item,
  input  serf_pkg::cfg_t cfg,
  output serf_pkg::out_t result
);
  import serf_pkg::*;

  // compare/width arithmetic runs at the wider of counter and field width
  localparam int CmpW = (COUNTER_BITS > WidthW) ? COUNTER_BITS : WidthW;

  logic [COUNTER_BITS-1:0] cnt_r, cnt_nxt;
  logic [COUNTER_BITS-1:0] start_r, start_nxt;
  logic [WidthW-1:0]       raw_r, raw_nxt;
  logic [WidthW-1:0]       lvw_r, lvw_nxt;
  logic [ErrW-1:0]         err_r, err_nxt;
  logic                    done_r, done_nxt;
  logic                    echo_prev_r;
  logic                    trig_r, trig_nxt;

  logic [COUNTER_BITS-1:0] diff;
  logic [CmpW-1:0]         diff_ext;
  logic [CmpW-1:0]         cnt_ext;
  logic [CmpW-1:0]         cmp_ext;
  logic                    out_of_range;

  assign diff     = cnt_r - start_r;
  assign diff_ext = CmpW'(diff);
  assign cnt_ext  = CmpW'(cnt_r);
  assign cmp_ext  = CmpW'(cfg.trigger_compare);

  always_comb begin
    start_nxt = start_r;
    raw_nxt   = raw_r;
    lvw_nxt   = lvw_r;
    err_nxt   = err_r;
    done_nxt  = done_r;
    trig_nxt  = trig_r;

    // echo edges
    if (item.echo_level && !echo_prev_r) begin
      start_nxt = cnt_r;
    end else if (!item.echo_level && echo_prev_r) begin
      raw_nxt  = diff_ext[WidthW-1:0];
      done_nxt = 1'b1;
    end

    // trigger compare: no echo this period means no reading
    if (cnt_ext == cmp_ext) begin
      if (!done_nxt) begin
        raw_nxt = '0;
      end
      trig_nxt = 1'b1;
    end

    cnt_nxt = cnt_r + 1'b1;
    if (cnt_nxt == '0) begin
      trig_nxt = 1'b0;
      done_nxt = 1'b0;
    end

    // read filter
    out_of_range = (raw_nxt < cfg.min_valid_width) || (raw_nxt > cfg.max_valid_width);
    if (item.read_request) begin
      if (out_of_range && (lvw_r != '0)) begin
        if (err_r > cfg.error_limit) begin
          raw_nxt = cfg.fallback_width;
        end else begin
          if (err_r != ErrMax) begin
            err_nxt = err_r + 1'b1;
          end
          raw_nxt = lvw_r;
        end
      end else begin
        err_nxt = '0;
        lvw_nxt = raw_nxt;
      end
    end

    result.trigger_level  = trig_nxt;
    result.read_done      = item.read_request;
    result.distance_ticks = item.read_request ? raw_nxt : '0;
    result.invalid_count  = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      start_r     <= '0;
      raw_r       <= '0;
      lvw_r       <= '0;
      err_r       <= '0;
      done_r      <= 1'b0;
      echo_prev_r <= 1'b0;
      trig_r      <= 1'b0;
    end else if (step) begin
      cnt_r       <= cnt_nxt;
      start_r     <= start_nxt;
      raw_r       <= raw_nxt;
      lvw_r       <= lvw_nxt;
      err_r       <= err_nxt;
      done_r      <= done_nxt;
      echo_prev_r <= item.echo_level;
      trig_r      <= trig_nxt;
    end
  end

endmodule

@@ hdl/sonar_echo_ranging_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sonar_echo_ranging_filter: sonar trigger and echo pulse timer
// Tick-driven trigger generator, echo width timer and filtered range read.
// ----------------------------------------------------------------------------
// Each input transaction is one timer tick carrying the sampled echo level and
// a read request; each produces exactly one result transaction. The block
// takes one tick per clock cycle while in_ready is high; tick state updates
// in the cycle a transaction is accepted and its result is registered in a
// two-entry output stage (output register plus skid register), so a stalled
// consumer holds back the input only once both entries are full; in_ready is
// a register output with no path from out_ready. The user must write
// configuration registers through cfg_we/cfg_index/cfg_wdata while the block
// is idle (not enforced by the block); they take effect on the next tick.
// ----------------------------------------------------------------------------
module sonar_echo_ranging_filter #(
  parameter int COUNTER_BITS = serf_pkg::CounterBitsDef
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // tick input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  serf_pkg::in_t                   in_data,
  // result output
  output logic                            out_valid,
  input  logic                            out_ready,
  output serf_pkg::out_t                  out_data,
  // register writes
  input  logic                            cfg_we,
  input  logic [serf_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [serf_pkg::CfgDataW-1:0]   cfg_wdata
);
  import serf_pkg::*;

  cfg_t cfg_r;
  out_t result;
  out_t out_r;
  out_t skid_r;
  logic out_valid_r;
  logic skid_valid_r;
  logic push;
  logic pop;

  // a tick is accepted whenever the skid entry is free
  assign in_ready  = !skid_valid_r;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  serf_core #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (push),
    .item   (in_data),
    .cfg    (cfg_r),
    .result (result)
  );

  // register file; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_compare <= TrigCmpRst;
      cfg_r.min_valid_width <= MinWidthRst;
      cfg_r.max_valid_width <= MaxWidthRst;
      cfg_r.error_limit     <= ErrLimitRst;
      cfg_r.fallback_width  <= FallbackRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegTrigCmp:  cfg_r.trigger_compare <= cfg_wdata;
        RegMinWidth: cfg_r.min_valid_width <= cfg_wdata;
        RegMaxWidth: cfg_r.max_valid_width <= cfg_wdata;
        RegErrLimit: cfg_r.error_limit     <= cfg_wdata[ErrW-1:0];
        RegFallback: cfg_r.fallback_width  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // output register + skid: results leave in order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= push;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      if (out_valid_r) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        out_r  <= skid_r;
        skid_r <= result;
      end else begin
        out_r  <= result;
      end
    end else if (push) begin
      if (out_valid_r) begin
        skid_r <= result;
      end else begin
        out_r  <= result;
      end
    end
  end

endmodule

@@ hdl/serf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serf_checker: port-level checks for the sonar echo ranging filter
// Watches the top-level ports; attached by the bind at the end of this file.
// ----------------------------------------------------------------------------
module serf_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input serf_pkg::out_t out_data
);
  import serf_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // after an accepted tick, a result is pending in the next cycle
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick produced no result");

  // input backpressure only when results are pending
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // no distance without a read
  a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.read_done |-> out_data.distance_ticks == '0)
    else $error("distance reported without read request");

endmodule

bind sonar_echo_ranging_filter serf_checker u_serf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
